// ===== design/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// stg_pkg: shared types, constants and microcode for the sine tone generator
// Field widths, register reset values, the sine table builder and the
// control program run by the sequencer.
// ----------------------------------------------------------------------------
package stg_pkg;

  // Default sizing
  localparam int SINE_TABLE_DEPTH  = 1024;
  localparam int MAX_BUFFER_LENGTH = 4096;

  // Field widths
  localparam int RATE_W   = 18;  // sample_rate, phase accumulator
  localparam int SCALE_W  = 20;  // phase_scale
  localparam int BLEN_W   = 13;  // buffer_length
  localparam int BMS_W    = 10;  // buffer_ms
  localparam int TONE_W   = 15;
  localparam int VOL_W    = 16;
  localparam int DUR_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int REMMS_W  = 17;  // signed remaining milliseconds
  localparam int SUM_W    = RATE_W + 1;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 48;
  localparam int ENTRY_W  = 17;  // signed table entry, -32768..32768

  // Shared multiplier
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int FRAC_W  = 32;

  // Register reset values
  localparam logic [RATE_W-1:0]  RATE_RST  = 18'd48000;
  localparam logic [SCALE_W-1:0] SCALE_RST = 20'd89478;
  localparam logic [BLEN_W-1:0]  BLEN_RST  = 13'd1024;
  localparam logic [BMS_W-1:0]   BMS_RST   = 10'd21;

  localparam logic [16:0] SAMPLE_MAX = 17'd32767;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE   = 2'd0,
    CFG_PHASE_SCALE   = 2'd1,
    CFG_BUFFER_LENGTH = 2'd2,
    CFG_BUFFER_MS     = 2'd3
  } cfg_idx_e;

  // Sine polynomial coefficients, Q30
  localparam longint Q30 = 64'sd1073741824;
  localparam longint A1  = 64'sd1686629713;
  localparam longint A3  = -64'sd693598668;
  localparam longint A5  = 64'sd85569306;
  localparam longint A7  = -64'sd5026995;
  localparam longint A9  = 64'sd172272;

  // One table entry from a 32-bit turn fraction; elaboration time only
  function automatic logic signed [ENTRY_W-1:0] sine_entry(input logic [31:0] u);
    logic [1:0] q;
    longint t;
    longint t2;
    longint p;
    longint s;
    longint v;
    q = u[31:30];
    t = longint'(u[29:0]);
    if (q[0]) begin
      t = Q30 - t;
    end
    t2 = (t * t) / Q30;
    p  = A9;
    p  = A7 + (p * t2) / Q30;
    p  = A5 + (p * t2) / Q30;
    p  = A3 + (p * t2) / Q30;
    p  = A1 + (p * t2) / Q30;
    s  = (p * t) / Q30;
    if (s < 0) begin
      s = 0;
    end
    v = (s + 16384) / 32768;
    if (v > 32768) begin
      v = 32768;
    end
    if (q[1]) begin
      v = -v;
    end
    return ENTRY_W'(v);
  endfunction

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DECIDE,   // latch playing/silent for this sample
    OP_PHASE,    // advance phase, or launch remainder unit
    OP_SIGN,     // latch sign of table entry
    OP_SAMPLE,   // scale magnitude, take remainder result
    OP_FINISH    // buffer bookkeeping, load output register
  } op_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_PH_SC,   // phase * phase_scale
    MUL_FR_DP,   // frac * table depth
    MUL_AMP_MAG  // amplitude * |entry|
  } mul_e;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_SILENT,   // jump to target when buffer is silent
    JC_WAIT_REM, // hold while remainder unit busy
    JC_WAIT_OUT  // hold while output register full
  } jc_e;

  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_DECIDE = 3'd0;
  localparam logic [PC_W-1:0] PC_INDEX  = 3'd1;
  localparam logic [PC_W-1:0] PC_PHASE  = 3'd2;
  localparam logic [PC_W-1:0] PC_SIGN   = 3'd3;
  localparam logic [PC_W-1:0] PC_SAMPLE = 3'd4;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd5;

  typedef struct packed {
    op_e              op;
    mul_e             mul;
    jc_e              jc;
    logic [PC_W-1:0]  target;
    logic             last;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    mul_e mul;
  } ctrl_t;

  typedef struct packed {
    logic silent;
    logic rem_busy;
    logic out_full;
  } status_t;

  // Control program, one word per step
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_DECIDE: w = '{op: OP_DECIDE, mul: MUL_PH_SC, jc: JC_SILENT,
                       target: PC_FINISH, last: 1'b0};
      PC_INDEX:  w = '{op: OP_NONE, mul: MUL_FR_DP, jc: JC_NEXT,
                       target: PC_DECIDE, last: 1'b0};
      PC_PHASE:  w = '{op: OP_PHASE, mul: MUL_NONE, jc: JC_NEXT,
                       target: PC_DECIDE, last: 1'b0};
      PC_SIGN:   w = '{op: OP_SIGN, mul: MUL_AMP_MAG, jc: JC_NEXT,
                       target: PC_DECIDE, last: 1'b0};
      PC_SAMPLE: w = '{op: OP_SAMPLE, mul: MUL_NONE, jc: JC_WAIT_REM,
                       target: PC_SAMPLE, last: 1'b0};
      PC_FINISH: w = '{op: OP_FINISH, mul: MUL_NONE, jc: JC_WAIT_OUT,
                       target: PC_FINISH, last: 1'b1};
      default:   w = '{op: OP_NONE, mul: MUL_NONE, jc: JC_NEXT,
                       target: PC_DECIDE, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== design/stg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// stg_sine_rom: sine lookup ROM
// Full-wave Q1.15 sine table built at elaboration, registered read.
// ----------------------------------------------------------------------------
module stg_sine_rom #(
  parameter int SineTableDepth = stg_pkg::SINE_TABLE_DEPTH
) (
  input  logic                                     clk_i,
  input  logic [$clog2(SineTableDepth)-1:0]        addr_i,
  output logic signed [stg_pkg::ENTRY_W-1:0]       data_o
);

  logic signed [stg_pkg::ENTRY_W-1:0] rom_w [SineTableDepth];
  logic signed [stg_pkg::ENTRY_W-1:0] data_q;

  // Table contents, entry k at angle k/depth of a turn
  for (genvar g = 0; g < SineTableDepth; g++) begin : g_entry
    localparam longint Angle = (longint'(g) << 32) / SineTableDepth;
    assign rom_w[g] = stg_pkg::sine_entry(32'(Angle));
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== design/stg_rem_unit.sv =====
// ----------------------------------------------------------------------------
// stg_rem_unit: phase remainder unit
// Restoring remainder, one dividend bit per cycle, for the phase wrap
// when phase plus step reaches twice the sample rate.
// ----------------------------------------------------------------------------
module stg_rem_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [stg_pkg::SUM_W-1:0]      dividend_i,
  input  logic [stg_pkg::RATE_W-1:0]     divisor_i,
  output logic                           busy_o,
  output logic [stg_pkg::RATE_W-1:0]     rem_o
);

  localparam int CntW = $clog2(stg_pkg::SUM_W + 1);

  logic [CntW-1:0]              cnt_q;
  logic [stg_pkg::SUM_W-1:0]    num_q;
  logic [stg_pkg::RATE_W-1:0]   div_q;
  logic [stg_pkg::RATE_W-1:0]   rem_q;
  logic [stg_pkg::SUM_W-1:0]    trial;
  logic [stg_pkg::SUM_W-1:0]    diff;
  logic                         fits;

  // One trial subtraction per cycle
  assign trial = {rem_q, num_q[stg_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  // Iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(stg_pkg::SUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[stg_pkg::SUM_W-2:0], 1'b0};
      rem_q <= fits ? diff[stg_pkg::RATE_W-1:0] : trial[stg_pkg::RATE_W-1:0];
    end
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

  // Remainder is below the divisor when the run ends
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(1)) |=> (rem_q < div_q))
    else $error("remainder not below divisor");

  // No new start while a run is in flight
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("remainder unit restarted while busy");

endmodule

// ===== design/stg_sequencer.sv =====
// ----------------------------------------------------------------------------
// stg_sequencer: microcode sequencer
// Step counter over the control program; issues one control word per
// cycle, holds on wait conditions and takes the silent-buffer jump.
// ----------------------------------------------------------------------------
module stg_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  stg_pkg::status_t  status_i,
  output stg_pkg::ctrl_t    ctrl_o,
  output logic              busy_o
);

  logic                        running_q, running_d;
  logic [stg_pkg::PC_W-1:0]    pc_q, pc_d;
  stg_pkg::ucode_t             uw;
  logic                        hold;
  logic                        jump;

  assign uw = stg_pkg::ucode(pc_q);

  // Condition evaluation
  always_comb begin
    hold = 1'b0;
    jump = 1'b0;
    case (uw.jc)
      stg_pkg::JC_NEXT:     ;
      stg_pkg::JC_SILENT:   jump = status_i.silent;
      stg_pkg::JC_WAIT_REM: hold = status_i.rem_busy;
      stg_pkg::JC_WAIT_OUT: hold = status_i.out_full;
      default:              ;
    endcase
  end

  // Next step
  always_comb begin
    running_d = running_q;
    pc_d      = pc_q;
    if (!running_q) begin
      if (start_i) begin
        running_d = 1'b1;
        pc_d      = stg_pkg::PC_DECIDE;
      end
    end else if (!hold) begin
      if (uw.last) begin
        running_d = 1'b0;
        pc_d      = stg_pkg::PC_DECIDE;
      end else if (jump) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + stg_pkg::PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pc_q      <= stg_pkg::PC_DECIDE;
    end else begin
      running_q <= running_d;
      pc_q      <= pc_d;
    end
  end

  // Ops commit only on a step that is not holding
  assign ctrl_o.op  = (running_q && !hold) ? uw.op : stg_pkg::OP_NONE;
  assign ctrl_o.mul = running_q ? uw.mul : stg_pkg::MUL_NONE;
  assign busy_o     = running_q;

  // Step counter stays inside the program
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (pc_q <= stg_pkg::PC_FINISH))
    else $error("step counter outside program");

endmodule

// ===== design/sine_tone_generator_unit.sv =====
// ----------------------------------------------------------------------------
// sine_tone_generator_unit: DDS sine tone with note length
// Start commands load tone, volume and duration; each tick yields one
// sample, grouped in audio buffers.
// ----------------------------------------------------------------------------
// A start command loads the note state; a tick runs the decide, index,
//   phase, sign, sample and finish steps, and a silent tick jumps from
//   decide to finish. No new item is taken until a tick is done; when the
//   phase sum reaches twice the sample rate, the remainder unit holds the sample step. A full
//   output register holds the finish step and the input until it drains.
// Reset: asynchronous, clears note state and loads register defaults.
// ----------------------------------------------------------------------------
module sine_tone_generator_unit #(
  parameter int SineTableDepth  = stg_pkg::SINE_TABLE_DEPTH,
  parameter int MaxBufferLength = stg_pkg::MAX_BUFFER_LENGTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tone_hz [14:0], volume [30:15], duration_ms [46:31], zero [47]
  input  logic [stg_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // command [0]
  input  logic                               s_axis_tuser_i,
  // Output stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // sample [15:0]
  output logic [stg_pkg::SAMPLE_W-1:0]       m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  // Register writes
  input  logic                               cfg_we_i,
  input  logic [stg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [stg_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int AddrW = $clog2(SineTableDepth);
  localparam int IdxW  = $clog2(MaxBufferLength);
  localparam int LenW  = $clog2(MaxBufferLength + 1);
  localparam int CmpW  = (LenW > stg_pkg::BLEN_W) ? LenW : stg_pkg::BLEN_W;

  // Registers
  logic [stg_pkg::RATE_W-1:0]   rate_q;
  logic [stg_pkg::SCALE_W-1:0]  scale_q;
  logic [stg_pkg::BLEN_W-1:0]   blen_q;
  logic [stg_pkg::BMS_W-1:0]    bms_q;

  // Note state
  logic [stg_pkg::RATE_W-1:0]          phase_q;
  logic [stg_pkg::TONE_W-1:0]          step_q;
  logic [stg_pkg::VOL_W-1:0]           amp_q;
  logic signed [stg_pkg::REMMS_W-1:0]  remms_q;
  logic [IdxW-1:0]                     idx_q;
  logic                                playing_q;
  logic                                slow_q;

  // Datapath payload
  logic [stg_pkg::PROD_W-1:0]          prod_q;
  logic                                neg_q;
  logic [stg_pkg::SAMPLE_W-1:0]        sample_q;

  // Output register
  logic                                m_valid_q;
  logic [stg_pkg::SAMPLE_W-1:0]        m_data_q;
  logic                                m_last_q;

  stg_pkg::ctrl_t                      ctrl;
  stg_pkg::status_t                    status;
  logic                                seq_busy;
  logic                                in_fire;
  logic                                start;

  // Input handshake
  assign s_axis_tready_o = !seq_busy;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign start           = in_fire && !s_axis_tuser_i;

  // Playing decision for the first sample of a buffer
  logic play_d;
  assign play_d = (idx_q == '0) ? (remms_q > 0) : playing_q;

  // Shared multiplier
  logic [stg_pkg::MUL_A_W-1:0] mul_a;
  logic [stg_pkg::MUL_B_W-1:0] mul_b;
  logic [stg_pkg::PROD_W-1:0]  mul_p;
  logic signed [stg_pkg::ENTRY_W-1:0] rom_data;
  logic [stg_pkg::ENTRY_W-1:0]        rom_abs;

  assign rom_abs = rom_data[stg_pkg::ENTRY_W-1] ? (stg_pkg::ENTRY_W'(0) - rom_data) : rom_data;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      stg_pkg::MUL_NONE:    ;
      stg_pkg::MUL_PH_SC: begin
        mul_a = stg_pkg::MUL_A_W'(phase_q);
        mul_b = scale_q;
      end
      stg_pkg::MUL_FR_DP: begin
        mul_a = prod_q[stg_pkg::FRAC_W-1:0];
        mul_b = stg_pkg::MUL_B_W'(SineTableDepth);
      end
      stg_pkg::MUL_AMP_MAG: begin
        mul_a = stg_pkg::MUL_A_W'(amp_q);
        mul_b = stg_pkg::MUL_B_W'(rom_abs[stg_pkg::SAMPLE_W-1:0]);
      end
      default: ;
    endcase
  end

  assign mul_p = stg_pkg::PROD_W'(mul_a) * stg_pkg::PROD_W'(mul_b);

  // Sine ROM, addressed by the integer part of frac * depth
  stg_sine_rom #(
    .SineTableDepth (SineTableDepth)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (prod_q[stg_pkg::FRAC_W +: AddrW]),
    .data_o (rom_data)
  );

  // Phase advance: direct wrap or remainder unit
  logic [stg_pkg::SUM_W-1:0]  sum;
  logic [stg_pkg::SUM_W-1:0]  sum_wrap;
  logic                       rate_zero;
  logic                       fast_lt;
  logic                       fast_one;
  logic                       rem_start;
  logic                       rem_busy;
  logic [stg_pkg::RATE_W-1:0] rem_val;

  assign sum       = {1'b0, phase_q} + stg_pkg::SUM_W'(step_q);
  assign sum_wrap  = sum - {1'b0, rate_q};
  assign rate_zero = (rate_q == '0);
  assign fast_lt   = sum < {1'b0, rate_q};
  assign fast_one  = sum_wrap < {1'b0, rate_q};
  assign rem_start = (ctrl.op == stg_pkg::OP_PHASE) && !rate_zero && !fast_lt && !fast_one;

  stg_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (sum),
    .divisor_i  (rate_q),
    .busy_o     (rem_busy),
    .rem_o      (rem_val)
  );

  // Sample magnitude: (32767 * amp * |entry|) >> 30, saturated
  logic [31:0]                  am_prod;
  logic [46:0]                  scaled;
  logic [16:0]                  mag_full;
  logic [14:0]                  mag_sat;
  logic [stg_pkg::SAMPLE_W-1:0] mag16;
  logic [stg_pkg::SAMPLE_W-1:0] smp;

  assign am_prod  = prod_q[31:0];
  assign scaled   = {am_prod, 15'd0} - 47'(am_prod);
  assign mag_full = scaled[46:30];
  assign mag_sat  = (mag_full > stg_pkg::SAMPLE_MAX) ? stg_pkg::SAMPLE_MAX[14:0]
                                                     : mag_full[14:0];
  assign mag16    = {1'b0, mag_sat};
  assign smp      = neg_q ? (stg_pkg::SAMPLE_W'(0) - mag16) : mag16;

  // Buffer end and duration bookkeeping
  logic [CmpW-1:0]                     blen_ext;
  logic [CmpW-1:0]                     max_len;
  logic [CmpW-1:0]                     len;
  logic                                last;
  logic signed [stg_pkg::REMMS_W-1:0]  remms_dec;
  logic signed [stg_pkg::REMMS_W-1:0]  remms_new;

  assign blen_ext  = CmpW'(blen_q);
  assign max_len   = CmpW'(MaxBufferLength);
  assign len       = (blen_q == '0) ? CmpW'(1) : ((blen_ext > max_len) ? max_len : blen_ext);
  assign last      = (CmpW'(idx_q) + CmpW'(1)) >= len;
  assign remms_dec = remms_q - $signed(stg_pkg::REMMS_W'(bms_q));
  assign remms_new = (last && playing_q) ? remms_dec : remms_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= stg_pkg::RATE_RST;
      scale_q <= stg_pkg::SCALE_RST;
      blen_q  <= stg_pkg::BLEN_RST;
      bms_q   <= stg_pkg::BMS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        stg_pkg::CFG_SAMPLE_RATE:   rate_q  <= cfg_data_i[stg_pkg::RATE_W-1:0];
        stg_pkg::CFG_PHASE_SCALE:   scale_q <= cfg_data_i[stg_pkg::SCALE_W-1:0];
        stg_pkg::CFG_BUFFER_LENGTH: blen_q  <= cfg_data_i[stg_pkg::BLEN_W-1:0];
        stg_pkg::CFG_BUFFER_MS:     bms_q   <= cfg_data_i[stg_pkg::BMS_W-1:0];
        default: ;
      endcase
    end
  end

  // Note state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      step_q    <= '0;
      amp_q     <= '0;
      remms_q   <= '0;
      idx_q     <= '0;
      playing_q <= 1'b0;
      slow_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      // Output drains; a finish step in the same cycle reloads it
      if (m_valid_q && m_axis_tready_i && (ctrl.op != stg_pkg::OP_FINISH)) begin
        m_valid_q <= 1'b0;
      end
      // Start command
      if (in_fire && s_axis_tuser_i) begin
        step_q  <= s_axis_tdata_i[14:0];
        amp_q   <= s_axis_tdata_i[30:15];
        remms_q <= $signed(stg_pkg::REMMS_W'(s_axis_tdata_i[46:31]));
      end
      case (ctrl.op)
        stg_pkg::OP_DECIDE: playing_q <= play_d;
        stg_pkg::OP_PHASE: begin
          if (rate_zero || fast_lt) begin
            slow_q  <= 1'b0;
            phase_q <= sum[stg_pkg::RATE_W-1:0];
          end else if (fast_one) begin
            slow_q  <= 1'b0;
            phase_q <= sum_wrap[stg_pkg::RATE_W-1:0];
          end else begin
            slow_q <= 1'b1;
          end
        end
        stg_pkg::OP_SAMPLE: begin
          if (slow_q) begin
            phase_q <= rem_val;
          end
        end
        stg_pkg::OP_FINISH: begin
          m_valid_q <= 1'b1;
          remms_q   <= remms_new;
          idx_q     <= last ? '0 : (idx_q + IdxW'(1));
          if (last && (remms_new < 0)) begin
            phase_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    if (ctrl.mul != stg_pkg::MUL_NONE) begin
      prod_q <= mul_p;
    end
    if (ctrl.op == stg_pkg::OP_SIGN) begin
      neg_q <= rom_data[stg_pkg::ENTRY_W-1];
    end
    if (ctrl.op == stg_pkg::OP_SAMPLE) begin
      sample_q <= smp;
    end
    if (ctrl.op == stg_pkg::OP_FINISH) begin
      m_data_q <= playing_q ? sample_q : '0;
      m_last_q <= last;
    end
  end

  // Sequencer
  assign status.silent   = !play_d;
  assign status.rem_busy = rem_busy;
  assign status.out_full = m_valid_q && !m_axis_tready_i;

  stg_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (seq_busy)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // A result only appears from the finish step
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(ctrl.op == stg_pkg::OP_FINISH))
    else $error("output valid without finish step");

  // A silent buffer gives zero samples
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == stg_pkg::OP_FINISH && !playing_q) |=> (m_axis_tdata_o == '0))
    else $error("silent sample not zero");

endmodule

// ===== verif/tb_sine_tone_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sine_tone_generator_unit: self-checking bench for the sine tone generator
// Drives start-note and tick transactions in random bursts against a receiver
// with its own stall pattern. A predictor in the bench tracks phase, note
// length and buffer position. Every output sample is checked in order against
// the predictor. A short table-driven directed run comes first. Randomized
// phases with different register settings follow.
// ----------------------------------------------------------------------------
module tb_sine_tone_generator_unit;

  localparam int ITEM_TARGET = 1450;
  localparam int SETTLE_CYCLES = 48;   // covers the slowest tick incl. remainder unit
  localparam int LONG_HOLD = 400;
  localparam longint ONE_Q30 = 64'sd1073741824;

  // Command codes carried on tuser
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic [stg_pkg::SAMPLE_W-1:0] smp;
    logic                         buffer_end;
  } tone_sample_t;

  typedef enum int {ROW_CFG, ROW_START, ROW_TICK, ROW_TICK_CHK} row_kind_e;

  // cfg: a=index b=value; start: a=tone b=volume c=duration; checked tick: a=sample b=last
  typedef struct {
    row_kind_e kind;
    int        a;
    int        b;
    int        c;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [stg_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic                          s_tuser = CMD_TICK;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [stg_pkg::SAMPLE_W-1:0]  m_tdata;
  logic                          m_tlast;
  logic                          cfg_we = 1'b0;
  stg_pkg::cfg_idx_e             cfg_index = stg_pkg::CFG_SAMPLE_RATE;
  logic [stg_pkg::CFG_W-1:0]     cfg_data = '0;

  // Predictor state and register copies
  int                                  sine_lut[stg_pkg::SINE_TABLE_DEPTH];
  logic [stg_pkg::RATE_W-1:0]          reg_rate;
  logic [stg_pkg::SCALE_W-1:0]         reg_scale;
  logic [stg_pkg::BLEN_W-1:0]          reg_blen;
  logic [stg_pkg::BMS_W-1:0]           reg_bms;
  logic [stg_pkg::RATE_W-1:0]          gen_phase;
  logic [stg_pkg::TONE_W-1:0]          gen_step;
  logic [stg_pkg::VOL_W-1:0]           gen_amp;
  logic signed [stg_pkg::REMMS_W-1:0]  gen_remain;
  logic [11:0]                         gen_index;
  bit                                  gen_playing;

  tone_sample_t pending_samples[$];
  dir_row_t     dir_rows[$];
  int           error_count = 0;
  int           items_sent = 0;
  int           burst_left = 0;
  int           holds_asked = 0;
  int           holds_served = 0;
  int unsigned  std_rates[9] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000, 96000, 192000};

  sine_tone_generator_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Q1.15 sine value for table slot k, odd polynomial evaluated in Q30
  function automatic int sine_lut_value(input int k);
    longint coef[5];
    longint ang;
    longint t;
    longint t2;
    longint p;
    longint s;
    longint v;
    coef = '{64'sd172272, -64'sd5026995, 64'sd85569306, -64'sd693598668, 64'sd1686629713};
    ang = (longint'(k) << 32) / stg_pkg::SINE_TABLE_DEPTH;
    t = ang & (ONE_Q30 - 1);
    if (ang[30]) begin
      t = ONE_Q30 - t;   // odd quadrant mirrors
    end
    t2 = (t * t) / ONE_Q30;
    p = coef[0];
    for (int i = 1; i < 5; i++) begin
      p = coef[i] + (p * t2) / ONE_Q30;
    end
    s = (p * t) / ONE_Q30;
    if (s < 0) begin
      s = 0;
    end
    v = (s + 16384) / 32768;
    if (v > 32768) begin
      v = 32768;
    end
    return ang[31] ? -int'(v) : int'(v);
  endfunction

  function automatic void reset_predictor();
    for (int k = 0; k < stg_pkg::SINE_TABLE_DEPTH; k++) begin
      sine_lut[k] = sine_lut_value(k);
    end
    reg_rate    = stg_pkg::RATE_RST;
    reg_scale   = stg_pkg::SCALE_RST;
    reg_blen    = stg_pkg::BLEN_RST;
    reg_bms     = stg_pkg::BMS_RST;
    gen_phase   = '0;
    gen_step    = '0;
    gen_amp     = '0;
    gen_remain  = '0;
    gen_index   = '0;
    gen_playing = 1'b0;
  endfunction

  function automatic void apply_reg(input stg_pkg::cfg_idx_e idx,
                                    input logic [stg_pkg::CFG_W-1:0] val);
    case (idx)
      stg_pkg::CFG_SAMPLE_RATE:   reg_rate  = val[stg_pkg::RATE_W-1:0];
      stg_pkg::CFG_PHASE_SCALE:   reg_scale = val[stg_pkg::SCALE_W-1:0];
      stg_pkg::CFG_BUFFER_LENGTH: reg_blen  = val[stg_pkg::BLEN_W-1:0];
      stg_pkg::CFG_BUFFER_MS:     reg_bms   = val[stg_pkg::BMS_W-1:0];
      default: ;
    endcase
  endfunction

  // Next sample of the tone generator for one transaction; start notes give none
  task automatic tone_predict(input logic cmd, input logic [stg_pkg::TONE_W-1:0] tone,
                              input logic [stg_pkg::VOL_W-1:0] vol,
                              input logic [stg_pkg::DUR_W-1:0] dur,
                              output bit makes_sample, output tone_sample_t res);
    int unsigned len;
    int unsigned ph_sum;
    int unsigned k;
    longint unsigned wide;
    longint unsigned mag;
    longint unsigned scaled;
    int entry;
    int smp;
    bit at_end;
    makes_sample = 1'b0;
    res = '0;
    smp = 0;
    if (cmd == CMD_START) begin
      gen_step   = tone;
      gen_amp    = vol;
      gen_remain = {1'b0, dur};
    end else begin
      len = reg_blen;
      if (len < 1) begin
        len = 1;
      end
      if (len > stg_pkg::MAX_BUFFER_LENGTH) begin
        len = stg_pkg::MAX_BUFFER_LENGTH;
      end
      // play/silent is latched on the first sample of a buffer
      if (gen_index == 0) begin
        gen_playing = (gen_remain > 0);
      end
      if (gen_playing) begin
        wide = gen_phase * reg_scale;
        wide = (wide & 64'hFFFF_FFFF) * stg_pkg::SINE_TABLE_DEPTH;
        k = int'(wide >> 32);
        entry = sine_lut[k];
        mag = (entry < 0) ? -entry : entry;
        scaled = (64'd32767 * gen_amp * mag) >> 30;
        if (scaled > 32767) begin
          scaled = 32767;   // volume above full scale
        end
        smp = (entry < 0) ? -int'(scaled) : int'(scaled);
        ph_sum = gen_phase + gen_step;
        if (reg_rate != 0) begin
          gen_phase = stg_pkg::RATE_W'(ph_sum % reg_rate);
        end else begin
          gen_phase = stg_pkg::RATE_W'(ph_sum);
        end
      end
      // shrunk length: an index past the end closes the buffer now
      at_end = (gen_index >= len - 1);
      if (at_end) begin
        gen_index = '0;
        if (gen_playing) begin
          gen_remain = gen_remain - stg_pkg::REMMS_W'(reg_bms);
        end
        if (gen_remain < 0) begin
          gen_phase = '0;
        end
      end else begin
        gen_index = gen_index + 1;
      end
      res.smp = smp[stg_pkg::SAMPLE_W-1:0];
      res.buffer_end = at_end;
      makes_sample = 1'b1;
    end
  endtask

  task automatic flag_error(input string what, input tone_sample_t want,
                            input tone_sample_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected sample %0d last %0b, got sample %0d last %0b", $time, what,
               $signed(want.smp), want.buffer_end, $signed(got.smp), got.buffer_end);
    end
  endtask

  // Output checker
  always @(posedge clk_i) begin
    tone_sample_t got;
    tone_sample_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.smp = m_tdata;
      got.buffer_end = m_tlast;
      if (pending_samples.size() == 0) begin
        flag_error("sample with none pending", '0, got);
      end else begin
        want = pending_samples.pop_front();
        if (got.smp !== want.smp || got.buffer_end !== want.buffer_end) begin
          flag_error("sample mismatch", want, got);
        end
      end
    end
  end

  // Receiver: stall pattern changes in stretches; long hold-off on request
  initial begin
    int hold_left;
    int mode_left;
    int rx_cyc;
    rx_mode_e mode;
    hold_left = 0;
    mode_left = 0;
    rx_cyc = 0;
    mode = RX_OPEN;
    forever begin
      @(negedge clk_i);
      rx_cyc++;
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:   m_tready <= (rx_cyc % 5 != 0);
        endcase
      end
    end
  end

  // One input transaction, then the sender's burst/gap pattern
  task automatic send_item(input logic cmd, input logic [stg_pkg::TONE_W-1:0] tone,
                           input logic [stg_pkg::VOL_W-1:0] vol,
                           input logic [stg_pkg::DUR_W-1:0] dur,
                           input bit fixed_exp, input tone_sample_t fixed_val);
    bit makes;
    tone_sample_t want;
    int gap;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, dur, vol, tone};
    @(posedge clk_i);
    while (!s_tready) begin
      @(posedge clk_i);
    end
    tone_predict(cmd, tone, vol, dur, makes, want);
    if (makes) begin
      pending_samples.push_back(fixed_exp ? fixed_val : want);
    end
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, stg_pkg::TONE_W'($urandom), stg_pkg::VOL_W'($urandom),
              stg_pkg::DUR_W'($urandom), 1'b0, '0);
  endtask

  task automatic send_note_start();
    logic [stg_pkg::TONE_W-1:0] tone;
    logic [stg_pkg::VOL_W-1:0] vol;
    logic [stg_pkg::DUR_W-1:0] dur;
    tone = ($urandom_range(0, 7) == 0) ? stg_pkg::TONE_W'($urandom)
                                       : stg_pkg::TONE_W'($urandom_range(0, 20000));
    case ($urandom_range(0, 7))
      0:       vol = 16'd32768;
      1:       vol = stg_pkg::VOL_W'($urandom);   // may exceed full scale
      default: vol = stg_pkg::VOL_W'($urandom_range(0, 32768));
    endcase
    case ($urandom_range(0, 9))
      0:       dur = '0;
      1:       dur = stg_pkg::DUR_W'($urandom);
      default: dur = stg_pkg::DUR_W'($urandom_range(0, 8 * reg_bms + 20));
    endcase
    send_item(CMD_START, tone, vol, dur, 1'b0, '0);
  endtask

  // Stop offering, wait for every pending sample, let the block go quiet
  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input stg_pkg::cfg_idx_e idx,
                           input logic [stg_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // New register setting for a random phase, extremes mixed in
  task automatic pick_settings();
    int unsigned sel;
    int unsigned rate;
    int unsigned scale;
    int unsigned blen;
    int unsigned bms;
    drain_results();
    sel = $urandom_range(0, 11);
    if (sel < 9) begin
      rate = std_rates[sel];
    end else if (sel == 9) begin
      rate = 0;
    end else if (sel == 10) begin
      rate = 262143;
    end else begin
      rate = $urandom_range(8000, 192000);
    end
    if (rate != 0) begin
      scale = int'(((64'd1 << 32) + rate / 2) / rate);
    end else begin
      scale = $urandom_range(1, 536871);
    end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       scale = 0;
        1:       scale = 1;
        2:       scale = 1048575;
        default: scale = $urandom & 20'hFFFFF;
      endcase
    end
    if ($urandom_range(0, 9) != 0) begin
      blen = $urandom_range(1, 24);
    end else begin
      case ($urandom_range(0, 4))
        0:       blen = 0;
        1:       blen = 1;
        2:       blen = 4096;
        3:       blen = 8191;
        default: blen = $urandom_range(25, 300);
      endcase
    end
    case ($urandom_range(0, 9))
      7:       bms = 0;
      8:       bms = 1000;
      9:       bms = 1023;
      default: bms = $urandom_range(1, 40);
    endcase
    write_reg(stg_pkg::CFG_SAMPLE_RATE, stg_pkg::CFG_W'(rate));
    write_reg(stg_pkg::CFG_PHASE_SCALE, stg_pkg::CFG_W'(scale));
    write_reg(stg_pkg::CFG_BUFFER_LENGTH, stg_pkg::CFG_W'(blen));
    write_reg(stg_pkg::CFG_BUFFER_MS, stg_pkg::CFG_W'(bms));
  endtask

  task automatic add_row(input row_kind_e kind, input int a, input int b, input int c);
    dir_row_t r;
    r.kind = kind;
    r.a = a;
    r.b = b;
    r.c = c;
    dir_rows.push_back(r);
  endtask

  // Main sequence
  initial begin
    int phase_no;
    int phase_end;
    int len_eff;
    int n_ticks;
    tone_sample_t typed;
    reset_predictor();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset state, extremes, clamps, mid-buffer start, zero rate and scale
    add_row(ROW_TICK_CHK, 0, 0, 0);
    add_row(ROW_CFG, stg_pkg::CFG_BUFFER_LENGTH, 1, 0);
    add_row(ROW_TICK_CHK, 0, 1, 0);            // index past new length ends buffer
    add_row(ROW_START, 1000, 32768, 65535);
    add_row(ROW_TICK_CHK, 0, 1, 0);            // phase zero reads a zero entry
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_START, 20000, 65535, 100);     // volume above full scale
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_CFG, stg_pkg::CFG_SAMPLE_RATE, 8000, 0);
    add_row(ROW_CFG, stg_pkg::CFG_PHASE_SCALE, 536871, 0);
    add_row(ROW_START, 32767, 32768, 50);      // step above the sample rate
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_CFG, stg_pkg::CFG_SAMPLE_RATE, 0, 0);   // phase wraps on its own width
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_CFG, stg_pkg::CFG_PHASE_SCALE, 0, 0);
    add_row(ROW_START, 1000, 32768, 1000);
    add_row(ROW_TICK_CHK, 0, 1, 0);            // zero scale always reads entry 0
    add_row(ROW_CFG, stg_pkg::CFG_PHASE_SCALE, 1048575, 0);
    add_row(ROW_CFG, stg_pkg::CFG_SAMPLE_RATE, 262143, 0);
    add_row(ROW_CFG, stg_pkg::CFG_BUFFER_MS, 0, 0);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_CFG, stg_pkg::CFG_BUFFER_MS, 1000, 0);
    add_row(ROW_CFG, stg_pkg::CFG_BUFFER_LENGTH, 6, 0);
    add_row(ROW_START, 700, 20000, 1500);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_START, 300, 12345, 0);         // new note mid-buffer
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_CFG, stg_pkg::CFG_BUFFER_LENGTH, 0, 0); // clamps to one sample
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_CFG, stg_pkg::CFG_BUFFER_LENGTH, 8191, 0);
    add_row(ROW_START, 5000, 32768, 65535);
    add_row(ROW_TICK, 0, 0, 0);
    add_row(ROW_CFG, stg_pkg::CFG_BUFFER_LENGTH, 4096, 0);
    add_row(ROW_TICK, 0, 0, 0);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          drain_results();
          write_reg(stg_pkg::cfg_idx_e'(dir_rows[i].a), stg_pkg::CFG_W'(dir_rows[i].b));
        end
        ROW_START: begin
          send_item(CMD_START, stg_pkg::TONE_W'(dir_rows[i].a), stg_pkg::VOL_W'(dir_rows[i].b),
                    stg_pkg::DUR_W'(dir_rows[i].c), 1'b0, '0);
        end
        ROW_TICK: begin
          send_item(CMD_TICK, '0, '0, '0, 1'b0, '0);
        end
        default: begin
          typed.smp = stg_pkg::SAMPLE_W'(dir_rows[i].a);
          typed.buffer_end = dir_rows[i].b[0];
          send_item(CMD_TICK, '0, '0, '0, 1'b1, typed);
        end
      endcase
    end

    // Random phases: notes with random content over short buffers
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      pick_settings();
      len_eff = (reg_blen < 1) ? 1 :
                (reg_blen > stg_pkg::MAX_BUFFER_LENGTH) ? stg_pkg::MAX_BUFFER_LENGTH :
                int'(reg_blen);
      phase_end = items_sent + $urandom_range(90, 140);
      if (phase_no == 2) begin
        holds_asked++;   // receiver holds off while notes keep coming
      end
      while (items_sent < phase_end) begin
        if (phase_no == 5 && items_sent > phase_end - 60 && items_sent < phase_end - 50) begin
          drain_results();
        end
        send_note_start();
        n_ticks = $urandom_range(1, (2 * len_eff + 4 > 60) ? 60 : 2 * len_eff + 4);
        repeat (n_ticks) begin
          if ($urandom_range(0, 15) == 0) begin
            send_note_start();
          end else begin
            send_tick();
          end
        end
      end
      phase_no++;
    end

    drain_results();
    if (error_count == 0 && pending_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
